/* hdl/kttab_pkg.sv */
// ----------------------------------------------------------------------------
// kttab_pkg
// Shared constants, codes and types for the keyed top-k table and its cells.
// ----------------------------------------------------------------------------
package kttab_pkg;

  // table geometry
  localparam int DEPTH      = 16;
  localparam int NAME_CHARS = 8;

  // stored and port widths
  localparam int KEY_W       = 8 * NAME_CHARS;
  localparam int FIELD_KEY_W = 64;
  localparam int SCORE_W     = 31;
  localparam int STATUS_W    = 3;
  localparam int RANK_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // at most this many entries are listed on a readout
  localparam int MAX_LIST = 16;

  // item kinds
  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_RAISED   = 3'd0,
    ST_KEPT     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_REPLACED = 3'd3,
    ST_REJECTED = 3'd4,
    ST_ENTRY    = 3'd5
  } status_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_READ
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic commit;  // apply a table change this cycle
    logic rotate;  // every cell takes its right neighbor (readout)
    logic raise;   // change is a raise of an existing entry
  } cell_ctrl_t;

endpackage

/* hdl/keyed_top_k_table.sv */
// Submit: request and compare results captured on acceptance, result registered from the
//   update state once out is free. Readout: one listed entry per cycle while out is not stalled;
//   the cell chain rotates once around so the table returns to its order.
// A new item is taken only back in idle; rate is set by the compare step, the single shift step and out stalls.
// Reset (rst, synchronous) empties the table: entry count cleared, slot contents left
//   as they are and never read before written; no clearing pass.
// ----------------------------------------------------------------------------
// keyed_top_k_table
// Score-ordered table of keyed entries built as a chain of cells, with
// update by key, sorted insertion, lowest-entry replacement and full readout.
// ----------------------------------------------------------------------------
module keyed_top_k_table (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  kind,
  input  logic [kttab_pkg::FIELD_KEY_W-1:0]     name_key,
  input  logic [kttab_pkg::SCORE_W-1:0]         score,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [kttab_pkg::STATUS_W-1:0]        status,
  output logic [kttab_pkg::RANK_W-1:0]          rank,
  output logic [kttab_pkg::FIELD_KEY_W-1:0]     entry_key,
  output logic [kttab_pkg::SCORE_W-1:0]         entry_score,
  output logic [kttab_pkg::COUNT_W-1:0]         entry_count,
  output logic                                  last
);
  import kttab_pkg::*;

  // control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   r;

  // captured request and compare results
  logic [KEY_W-1:0]   req_key;
  logic [SCORE_W-1:0] req_score;
  logic [DEPTH-1:0]   match_vec;
  logic [DEPTH-1:0]   ge_vec;
  logic [IDX_W-1:0]   m_reg;
  logic               hit_reg;
  logic [SCORE_W-1:0] kept_score;

  // cell chain signals
  logic [KEY_W-1:0]   cell_key   [DEPTH];
  logic [SCORE_W-1:0] cell_score [DEPTH];
  logic [DEPTH-1:0]   cell_hit;
  logic [DEPTH-1:0]   cell_ge;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   upto_match;
  logic [DEPTH:0]     ge_ext;
  cell_ctrl_t         ctrl;

  // derived values
  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic [IDX_W-1:0]   m_enc;
  logic [SCORE_W-1:0] kept_sel;
  logic [IDX_W-1:0]   pos;
  logic               raise;
  logic               full;
  logic [CNT_W-1:0]   list_cnt;
  logic               read_done;
  logic               read_emit;

  // result values ahead of the output register
  status_t            res_status;
  logic [RANK_W-1:0]  res_rank;
  logic [KEY_W-1:0]   res_key;
  logic [SCORE_W-1:0] res_score;
  logic [CNT_W-1:0]   res_count;
  logic               res_last;

  // output register
  status_t            out_status;
  logic [RANK_W-1:0]  out_rank;
  logic [KEY_W-1:0]   out_key;
  logic [SCORE_W-1:0] out_score;
  logic [CNT_W-1:0]   out_count;
  logic               out_last;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // chain neighbor view: ge_ext[j] is the ge flag of the cell left of j
  assign ge_ext = {ge_vec, 1'b1};

  // cell chain
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    assign occ[j]        = (CNT_W'(j) < count);
    assign upto_match[j] = (IDX_W'(j) <= m_reg);

    ktt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ[j]),
      .ge_left     (ge_ext[j]),
      .ge_self     (ge_vec[j]),
      .upto_match  (upto_match[j]),
      .cmp_key     (name_key[KEY_W-1:0]),
      .cmp_score   (score),
      .new_key     (req_key),
      .new_score   (req_score),
      .left_key    (cell_key[(j == 0) ? 0 : j - 1]),
      .left_score  (cell_score[(j == 0) ? 0 : j - 1]),
      .right_key   (cell_key[(j + 1) % DEPTH]),
      .right_score (cell_score[(j + 1) % DEPTH]),
      .key         (cell_key[j]),
      .score       (cell_score[j]),
      .hit         (cell_hit[j]),
      .ge          (cell_ge[j])
    );
  end

  // match index and kept score from the one-hot hit vector
  always_comb begin
    m_enc    = '0;
    kept_sel = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (cell_hit[j]) begin
        m_enc    = m_enc | IDX_W'(j);
        kept_sel = kept_sel | cell_score[j];
      end
    end
  end

  // insert point: boundary of the ge thermometer
  always_comb begin
    pos = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (ge_ext[j] && !ge_vec[j]) begin
        pos = pos | IDX_W'(j);
      end
    end
  end

  // readout length, capped at the listing limit
  always_comb begin
    if (int'(count) > MAX_LIST) begin
      list_cnt = CNT_W'(MAX_LIST);
    end else begin
      list_cnt = count;
    end
  end

  assign raise     = hit_reg && (req_score > kept_score);
  assign full      = (count == CNT_W'(DEPTH));
  assign read_done = (r == IDX_W'(DEPTH - 1));
  assign read_emit = (CNT_W'(r) < list_cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (kind == KIND_READ) begin
            state_next = (count != '0) ? S_READ : S_IDLE;
          end else begin
            state_next = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        if (out_free) state_next = S_IDLE;
      end
      S_READ: begin
        if (out_free && read_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, cell control and result values
  always_comb begin
    in_stall    = 1'b1;
    out_load    = 1'b0;
    ctrl        = '0;
    count_next  = count;
    res_status  = ST_ENTRY;
    res_rank    = RANK_W'(r);
    res_key     = cell_key[0];
    res_score   = cell_score[0];
    res_count   = count;
    res_last    = ((CNT_W'(r) + CNT_W'(1)) == list_cnt);
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_UPDATE: begin
        res_key   = req_key;
        res_score = req_score;
        res_rank  = RANK_W'(pos);
        res_last  = 1'b1;
        ctrl.raise = raise;
        if (hit_reg) begin
          if (raise) begin
            res_status  = ST_RAISED;
            ctrl.commit = out_free;
          end else begin
            res_status = ST_KEPT;
            res_rank   = RANK_W'(m_reg);
            res_score  = kept_score;
          end
        end else if (!full) begin
          res_status  = ST_INSERTED;
          ctrl.commit = out_free;
          res_count   = count + CNT_W'(1);
          if (out_free) count_next = count + CNT_W'(1);
        end else if (!ge_vec[DEPTH-1]) begin
          res_status  = ST_REPLACED;
          ctrl.commit = out_free;
        end else begin
          res_status = ST_REJECTED;
          res_rank   = '0;
        end
        out_load = out_free;
      end
      S_READ: begin
        ctrl.rotate = out_free;
        out_load    = out_free && read_emit;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      r         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (in_xfer) begin
        r <= '0;
      end else if (state == S_READ && out_free) begin
        r <= r + IDX_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and compare results on the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_key    <= name_key[KEY_W-1:0];
      req_score  <= score;
      match_vec  <= cell_hit;
      ge_vec     <= cell_ge;
      m_reg      <= m_enc;
      hit_reg    <= |cell_hit;
      kept_score <= kept_sel;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_rank   <= res_rank;
      out_key    <= res_key;
      out_score  <= res_score;
      out_count  <= res_count;
      out_last   <= res_last;
    end
  end

  assign status      = out_status;
  assign rank        = out_rank;
  assign entry_key   = FIELD_KEY_W'(out_key);
  assign entry_score = out_score;
  assign entry_count = COUNT_W'(out_count);
  assign last        = out_last;

`ifndef SYNTHESIS
  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  // at most one slot matches a key
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> $onehot0(match_vec))
    else $error("key found in more than one slot");

  // table order: ge flags form a thermometer from slot zero
  a_ge_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> ((ge_vec & (ge_vec + DEPTH'(1))) == '0))
    else $error("table lost its score order");

  // a result is never written over one still waiting
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded while output stalled");
`endif

endmodule

/* hdl/ktt_cell.sv */
// ----------------------------------------------------------------------------
// ktt_cell
// One table slot: holds a key and score, compares them against the incoming
// item, and takes new contents from the item or from a neighbor.
// ----------------------------------------------------------------------------
module ktt_cell (
  input  logic                            clk,
  input  kttab_pkg::cell_ctrl_t           ctrl,
  input  logic                            occ,
  input  logic                            ge_left,
  input  logic                            ge_self,
  input  logic                            upto_match,
  input  logic [kttab_pkg::KEY_W-1:0]     cmp_key,
  input  logic [kttab_pkg::SCORE_W-1:0]   cmp_score,
  input  logic [kttab_pkg::KEY_W-1:0]     new_key,
  input  logic [kttab_pkg::SCORE_W-1:0]   new_score,
  input  logic [kttab_pkg::KEY_W-1:0]     left_key,
  input  logic [kttab_pkg::SCORE_W-1:0]   left_score,
  input  logic [kttab_pkg::KEY_W-1:0]     right_key,
  input  logic [kttab_pkg::SCORE_W-1:0]   right_score,
  output logic [kttab_pkg::KEY_W-1:0]     key,
  output logic [kttab_pkg::SCORE_W-1:0]   score,
  output logic                            hit,
  output logic                            ge
);
  import kttab_pkg::*;

  logic [KEY_W-1:0]   key_next;
  logic [SCORE_W-1:0] score_next;

  // compare against the incoming item
  assign hit = occ && (key == cmp_key);
  assign ge  = occ && (score >= cmp_score);

  // slot update: a rotate takes the right neighbor; on a commit, cells above the insert point
  // hold, the insert point loads, cells below it shift down (up to the old match slot on a raise)
  always_comb begin
    key_next   = key;
    score_next = score;
    if (ctrl.rotate) begin
      key_next   = right_key;
      score_next = right_score;
    end else if (ctrl.commit && !ge_self) begin
      if (ge_left) begin
        key_next   = new_key;
        score_next = new_score;
      end else if (!ctrl.raise || upto_match) begin
        key_next   = left_key;
        score_next = left_score;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    key   <= key_next;
    score <= score_next;
  end

endmodule
